>>> sv/paff_pkg.sv
// ----------------------------------------------------------------------------
// paff_pkg: shared types and constants of the position/accel fusion filter
// Holds the sequencer types, register indexes and the serial unit widths.
// ----------------------------------------------------------------------------
package paff_pkg;

    localparam int DT_FRAC_BITS = 16;
    localparam int GAIN_BITS    = 16;

    // serial multiplier: signed A times unsigned B
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: unsigned numerator over unsigned denominator
    localparam int DIV_N_W = 49;
    localparam int DIV_D_W = 34;

    typedef enum logic [1:0] {
        CFG_POS_VAR = 2'd0,
        CFG_ACC_VAR = 2'd1,
        CFG_GUARD   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        S_DT2,
        S_VFA,
        S_VFP,
        S_VARP,
        S_AVDT,
        S_GM,
        S_MV1,
        S_MV2,
        S_MVV1,
        S_MVV2,
        S_VEDT,
        S_AEDT2,
        S_AEDT,
        S_ADT2,
        S_VVDT2,
        S_ADT4,
        S_GP,
        S_GV,
        S_GA,
        S_PEF,
        S_VEF,
        S_AEF,
        S_PV,
        S_VV,
        S_AV
    } step_t;

endpackage

>>> sv/paff_mul.sv
// ----------------------------------------------------------------------------
// paff_mul: bit-serial multiplier
// Signed A times unsigned B, one bit of B per cycle.
// ----------------------------------------------------------------------------
module paff_mul (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [paff_pkg::MUL_A_W-1:0] a,
    input  logic        [paff_pkg::MUL_B_W-1:0] b,
    output logic                                busy,
    output logic signed [paff_pkg::MUL_P_W-1:0] prod
);
    import paff_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W:0]   hi_reg;
    logic        [MUL_B_W-1:0] lo_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic                      busy_reg;
    logic signed [MUL_A_W:0]   sum;

    assign sum  = hi_reg + (lo_reg[0] ? {a_reg[MUL_A_W-1], a_reg} : '0);
    assign busy = busy_reg;
    assign prod = {hi_reg[MUL_A_W-1:0], lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(MUL_B_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            // add, then shift the product pair right by one
            hi_reg <= {sum[MUL_A_W], sum[MUL_A_W:1]};
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

endmodule

>>> sv/paff_div.sv
// ----------------------------------------------------------------------------
// paff_div: bit-serial restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module paff_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [paff_pkg::DIV_N_W-1:0] num,
    input  logic [paff_pkg::DIV_D_W-1:0] den,
    output logic                         busy,
    output logic [paff_pkg::DIV_N_W-1:0] quot
);
    import paff_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};
    assign busy  = busy_reg;
    assign quot  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_N_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end else if (busy_reg) begin
            // shift in the next numerator bit, keep the remainder below den
            rem_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
        end
    end

endmodule

>>> sv/position_accel_fusion_filter_core.sv
// ----------------------------------------------------------------------------
// position_accel_fusion_filter_core: scalar Kalman fusion of position and accel
// Sequencer over one serial multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per sensor sample (position, accel, time step).
//   m_ channel: one beat per sample with the updated position, velocity and
//   acceleration estimates.
//   cfg port: write the two sensor variances and the divide guard while idle.
// Steps: a sample runs 25 steps, 19 multiplies and 6 divides, each on the
//   bit-serial multiplier or divider. A new sample is not accepted until the
//   result of the last one has been loaded into the output register.
// The result sits in an output register; a stalled receiver holds it there,
//   and the next sample computes meanwhile and waits at the end for the slot.
// Reset: estimates clear to zero, variances to one, config to its defaults.
// ----------------------------------------------------------------------------
module position_accel_fusion_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // meas_position, meas_accel, time_step
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // est_position, est_velocity, est_accel
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);
    import paff_pkg::*;

    localparam logic [16:0] GAIN_ONE = 17'h10000;

    function automatic logic signed [67:0] sx68(input logic [31:0] x);
        return {{36{x[31]}}, x};
    endfunction

    function automatic logic signed [67:0] zx68(input logic [31:0] x);
        return {36'b0, x};
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [67:0] x);
        if (x[67:31] == {37{x[31]}}) begin
            return x[31:0];
        end
        return x[67] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    function automatic logic [31:0] sat_u32(input logic signed [67:0] x);
        return (|x[67:32]) ? 32'hffff_ffff : x[31:0];
    endfunction

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic [31:0] cfg_pos_var_reg, cfg_acc_var_reg;
    logic [15:0] cfg_guard_reg;

    logic [31:0] pe_reg, ve_reg, ae_reg, pv_reg, vv_reg, av_reg;
    logic [31:0] mp_reg, ma_reg, dt2_reg;
    logic [15:0] dt_reg;
    logic [31:0] vfa_reg, vfp_reg, measv_reg, pen_reg, ven_reg;
    logic [31:0] varp_reg, vara_reg, measvv_reg, adt2_reg, pvn_reg, vvn_reg;
    logic [16:0] gm_reg, gp_reg, gv_reg, ga_reg;
    logic signed [67:0] acc_reg;
    logic        m_valid_reg;
    logic [95:0] m_data_reg;

    logic                      mul_start, mul_busy;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic                      div_start, div_busy;
    logic [DIV_N_W-1:0]        div_num, div_quot;
    logic [DIV_D_W-1:0]        div_den;

    logic               div_step, unit_busy, wb_en, out_load;
    logic [15:0]        dtd;
    logic [32:0]        diff33, mag33;
    logic signed [67:0] pext, qext;
    logic [16:0]        gain_q;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign dtd    = (dt_reg == 16'd0) ? 16'd1 : dt_reg;
    assign diff33 = {mp_reg[31], mp_reg} - {pe_reg[31], pe_reg};
    assign mag33  = diff33[32] ? (~diff33 + 33'd1) : diff33;
    assign pext   = {{(68 - MUL_P_W){mul_prod[MUL_P_W-1]}}, mul_prod};
    assign qext   = {{(68 - DIV_N_W){1'b0}}, div_quot};
    assign gain_q = (div_den == '0) ? 17'd0 : div_quot[16:0];

    always_comb begin
        case (step_reg) inside
            S_VFP, S_VARP, S_GM, S_GP, S_GV, S_GA: div_step = 1'b1;
            default:                               div_step = 1'b0;
        endcase
    end

    assign unit_busy = div_step ? div_busy : mul_busy;
    assign mul_start = (state_reg == ST_START) && !div_step;
    assign div_start = (state_reg == ST_START) && div_step;
    assign wb_en     = (state_reg == ST_WAIT) && !unit_busy;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // operand select for the current step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        unique case (step_reg)
            S_DT2: begin
                mul_a = {18'b0, dt_reg};
                mul_b = {16'b0, dt_reg};
            end
            S_VFA: begin
                mul_a = {{2{ma_reg[31]}}, ma_reg};
                mul_b = {16'b0, dt_reg};
            end
            S_VFP: begin
                div_num = {mag33, {DT_FRAC_BITS{1'b0}}};
                div_den = {18'b0, dtd};
            end
            S_VARP: begin
                div_num = {1'b0, pv_reg, {DT_FRAC_BITS{1'b0}}};
                div_den = {18'b0, dtd};
            end
            S_AVDT: begin
                mul_a = {2'b0, av_reg};
                mul_b = {16'b0, dt_reg};
            end
            S_GM: begin
                div_num = {1'b0, varp_reg, {GAIN_BITS{1'b0}}};
                div_den = {2'b0, varp_reg} + {2'b0, vara_reg};
            end
            S_MV1: begin
                mul_a = {{2{vfp_reg[31]}}, vfp_reg};
                mul_b = {15'b0, GAIN_ONE - gm_reg};
            end
            S_MV2: begin
                mul_a = {{2{vfa_reg[31]}}, vfa_reg};
                mul_b = {15'b0, gm_reg};
            end
            S_MVV1: begin
                mul_a = {2'b0, varp_reg};
                mul_b = {15'b0, GAIN_ONE - gm_reg};
            end
            S_MVV2: begin
                mul_a = {2'b0, vara_reg};
                mul_b = {15'b0, gm_reg};
            end
            S_VEDT: begin
                mul_a = {{2{ve_reg[31]}}, ve_reg};
                mul_b = {16'b0, dt_reg};
            end
            S_AEDT2: begin
                mul_a = {{2{ae_reg[31]}}, ae_reg};
                mul_b = dt2_reg;
            end
            S_AEDT: begin
                mul_a = {{2{ae_reg[31]}}, ae_reg};
                mul_b = {16'b0, dt_reg};
            end
            S_ADT2: begin
                mul_a = {2'b0, av_reg};
                mul_b = dt2_reg;
            end
            S_VVDT2: begin
                mul_a = {2'b0, vv_reg};
                mul_b = dt2_reg;
            end
            S_ADT4: begin
                mul_a = {2'b0, adt2_reg};
                mul_b = dt2_reg;
            end
            S_GP: begin
                div_num = {1'b0, pvn_reg, {GAIN_BITS{1'b0}}};
                div_den = {2'b0, pvn_reg} + {2'b0, cfg_pos_var_reg} + {18'b0, cfg_guard_reg};
            end
            S_GV: begin
                div_num = {1'b0, vvn_reg, {GAIN_BITS{1'b0}}};
                div_den = {2'b0, vvn_reg} + {2'b0, measvv_reg} + {18'b0, cfg_guard_reg};
            end
            S_GA: begin
                div_num = {1'b0, av_reg, {GAIN_BITS{1'b0}}};
                div_den = {2'b0, av_reg} + {2'b0, cfg_acc_var_reg} + {18'b0, cfg_guard_reg};
            end
            S_PEF: begin
                mul_a = {{2{mp_reg[31]}}, mp_reg} - {{2{pen_reg[31]}}, pen_reg};
                mul_b = {15'b0, gp_reg};
            end
            S_VEF: begin
                mul_a = {{2{measv_reg[31]}}, measv_reg} - {{2{ven_reg[31]}}, ven_reg};
                mul_b = {15'b0, gv_reg};
            end
            S_AEF: begin
                mul_a = {{2{ma_reg[31]}}, ma_reg} - {{2{ae_reg[31]}}, ae_reg};
                mul_b = {15'b0, ga_reg};
            end
            S_PV: begin
                mul_a = {2'b0, pvn_reg};
                mul_b = {15'b0, GAIN_ONE - gp_reg};
            end
            S_VV: begin
                mul_a = {2'b0, vvn_reg};
                mul_b = {15'b0, GAIN_ONE - gv_reg};
            end
            S_AV: begin
                mul_a = {2'b0, av_reg};
                mul_b = {15'b0, GAIN_ONE - ga_reg};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START;
                    step_next  = S_DT2;
                end
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (!unit_busy) begin
                    if (step_reg == S_AV) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_START;
                        step_next  = step_t'(5'(step_reg + 5'd1));
                    end
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= S_DT2;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_pos_var_reg <= 32'h0001_0000;
            cfg_acc_var_reg <= 32'h0001_0000;
            cfg_guard_reg   <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_POS_VAR: cfg_pos_var_reg <= cfg_wr_data;
                CFG_ACC_VAR: cfg_acc_var_reg <= cfg_wr_data;
                CFG_GUARD:   cfg_guard_reg   <= cfg_wr_data[15:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {ae_reg, ve_reg, pe_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mp_reg <= s_tdata[31:0];
            ma_reg <= s_tdata[63:32];
            dt_reg <= s_tdata[79:64];
        end
    end

    // filter state: estimates and variances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pe_reg <= '0;
            ve_reg <= '0;
            ae_reg <= '0;
            pv_reg <= 32'h0001_0000;
            vv_reg <= 32'h0001_0000;
            av_reg <= 32'h0001_0000;
        end else if (wb_en) begin
            case (step_reg)
                S_PEF:   pe_reg <= sat_s32(sx68(pen_reg) + (pext >>> GAIN_BITS));
                S_VEF:   ve_reg <= sat_s32(sx68(ven_reg) + (pext >>> GAIN_BITS));
                S_AEF:   ae_reg <= sat_s32(sx68(ae_reg) + (pext >>> GAIN_BITS));
                S_PV:    pv_reg <= sat_u32(pext >>> GAIN_BITS);
                S_VV:    vv_reg <= sat_u32(pext >>> GAIN_BITS);
                S_AV:    av_reg <= sat_u32(pext >>> GAIN_BITS);
                default: ;
            endcase
        end
    end

    // per-sample intermediates
    always_ff @(posedge aclk) begin
        if (wb_en) begin
            case (step_reg)
                S_DT2:   dt2_reg <= mul_prod[31:0];
                S_VFA:   vfa_reg <= sat_s32(sx68(ve_reg) + (pext >>> DT_FRAC_BITS));
                S_VFP:   vfp_reg <= sat_s32(diff33[32] ? -qext : qext);
                S_VARP:  varp_reg <= sat_u32(qext);
                S_AVDT:  vara_reg <= sat_u32(zx68(vv_reg) + zx68(sat_u32(pext >>> DT_FRAC_BITS)));
                S_GM:    gm_reg <= gain_q;
                S_MV1:   acc_reg <= pext;
                S_MV2:   measv_reg <= sat_s32((acc_reg + pext) >>> GAIN_BITS);
                S_MVV1:  acc_reg <= pext;
                S_MVV2:  measvv_reg <= sat_u32((acc_reg + pext) >>> GAIN_BITS);
                S_VEDT:  acc_reg <= pext >>> DT_FRAC_BITS;
                S_AEDT2: pen_reg <= sat_s32(sx68(pe_reg) + acc_reg
                                            + (pext >>> (2 * DT_FRAC_BITS + 1)));
                S_AEDT:  ven_reg <= sat_s32(sx68(ve_reg) + (pext >>> DT_FRAC_BITS));
                S_ADT2:  adt2_reg <= sat_u32(pext >>> (2 * DT_FRAC_BITS));
                S_VVDT2: acc_reg <= zx68(sat_u32(pext >>> (2 * DT_FRAC_BITS)));
                S_ADT4: begin
                    pvn_reg <= sat_u32(zx68(pv_reg) + acc_reg
                                       + zx68(sat_u32(pext >>> (2 * DT_FRAC_BITS + 2))));
                    vvn_reg <= sat_u32(zx68(vv_reg) + zx68(adt2_reg));
                end
                S_GP:    gp_reg <= gain_q;
                S_GV:    gv_reg <= gain_q;
                S_GA:    ga_reg <= gain_q;
                default: ;
            endcase
        end
    end

    paff_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .prod    (mul_prod)
    );

    paff_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

endmodule

>>> sv/paff_checker.sv
// ----------------------------------------------------------------------------
// paff_checker: port-level checks for the fusion filter core
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module paff_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // an accepted sample blocks further input while it computes
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a result cannot appear in the cycle right after a sample enters
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind position_accel_fusion_filter_core paff_checker u_paff_checker (.*);
